/* src/ffha_pkg.sv */
// Shared codes for the first-fit heap allocator.
package ffha_pkg;

   // Request kinds carried by the request type bit.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADSIZE = 2'd2;
   localparam logic [1:0] ST_BADFREE = 2'd3;

endpackage

/* src/first_fit_heap_allocator.sv */
// First-fit heap allocator: top level with the request sequencer over the header memory.
// Allocate walks the block headers from the start of the arena and writes a new header when the block splits.
// Free checks and releases the block, then walks the arena again, merging each free block with
// a free neighbor and checking that block again after each merge.
// Throughput: one request at a time, since the sequencer takes a request only while idle.
// Reset: a clearing pass zeroes the header memory, with no request taken.
module first_fit_heap_allocator #(
   parameter int ARENA_BYTES  = 4096,
   parameter int HEADER_BYTES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [11:0] req_request_size,
   input  logic [11:0] req_payload_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_granted_address,
   output logic [1:0]  rsp_status
);

   localparam int AW = $clog2(ARENA_BYTES);
   localparam int XW = (AW + 1 > 13) ? AW + 1 : 13;
   localparam int EW = AW + 2;
   localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
   localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);
   localparam logic [XW-1:0] LIM_X   = XW'(ARENA_BYTES - HEADER_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(ARENA_BYTES - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_AINIT, S_ARD, S_AEV, S_ASPLIT,
      S_FCHK, S_FEV, S_CRD, S_CEV, S_CNX, S_CKILL, S_RESP
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          ready_ff, ready_in;
   logic [XW-1:0] off_ff, off_in;
   logic [XW-1:0] nx_ff, nx_in;
   logic [AW-1:0] cur_sz_ff, cur_sz_in;
   logic [XW-1:0] req_sz_ff, req_sz_in;
   logic [XW-1:0] p_ff, p_in;
   logic [XW-1:0] rest_ff, rest_in;
   logic [AW-1:0] rest_sz_ff, rest_sz_in;
   logic [1:0]    st_ff, st_in;
   logic [11:0]   addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [11:0]   rsp_addr_ff, rsp_addr_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_idx, rd_idx;
   logic [EW-1:0] wr_data, rd_data;

   logic          rv, ra;
   logic [XW-1:0] rs, nx_sum, fo, rest_x, pay_x;
   logic          fits, split;

   ffha_hdr_ram #(.DEPTH(ARENA_BYTES), .WIDTH(EW), .AW(AW)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // Fields of the header just read, and the offsets derived from it.
   assign rv     = rd_data[AW+1];
   assign ra     = rd_data[AW];
   assign rs     = XW'(rd_data[AW-1:0]);
   assign nx_sum = off_ff + HDR_X + rs;
   assign fo     = p_ff - HDR_X;
   assign fits   = !ra && (rs >= req_sz_ff);
   assign split  = rs >= req_sz_ff + HDR_X + XW'(1);
   assign rest_x = off_ff + HDR_X + req_sz_ff;
   assign pay_x  = off_ff + HDR_X;

   // Sequencer: next state, memory accesses and result.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ready_in      = ready_ff;
      off_in        = off_ff;
      nx_in         = nx_ff;
      cur_sz_in     = cur_sz_ff;
      req_sz_in     = req_sz_ff;
      p_in          = p_ff;
      rest_in       = rest_ff;
      rest_sz_in    = rest_sz_ff;
      st_in         = st_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_idx        = off_ff[AW-1:0];
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_idx        = off_ff[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            wr_idx = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_sz_in = XW'(req_request_size);
               p_in      = XW'(req_payload_address);
               st_in     = ffha_pkg::ST_OK;
               addr_in   = '0;
               state_in  = (req_type == ffha_pkg::REQ_FREE) ? S_FCHK : S_AINIT;
            end
         end
         S_AINIT: begin
            // The first allocate turns the arena into one free block.
            if (!ready_ff) begin
               wr_en    = 1'b1;
               wr_idx   = '0;
               wr_data  = {1'b1, 1'b0, AW'(ARENA_BYTES - HEADER_BYTES)};
               ready_in = 1'b1;
            end
            if (req_sz_ff > LIM_X) begin
               st_in    = ffha_pkg::ST_BADSIZE;
               state_in = S_RESP;
            end else begin
               off_in   = '0;
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            if (off_ff >= ARENA_X) begin
               st_in    = ffha_pkg::ST_NOSPACE;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_AEV;
            end
         end
         S_AEV: begin
            if (!rv) begin
               st_in    = ffha_pkg::ST_NOSPACE;
               state_in = S_RESP;
            end else if (fits) begin
               // Take this block, shrinking it when the rest can stand alone.
               wr_en      = 1'b1;
               wr_data    = {1'b1, 1'b1, split ? req_sz_ff[AW-1:0] : rd_data[AW-1:0]};
               addr_in    = pay_x[11:0];
               st_in      = ffha_pkg::ST_OK;
               rest_in    = rest_x;
               rest_sz_in = AW'(rs - req_sz_ff - HDR_X);
               state_in   = (split && rest_x < ARENA_X) ? S_ASPLIT : S_RESP;
            end else begin
               off_in   = nx_sum;
               state_in = S_ARD;
            end
         end
         S_ASPLIT: begin
            wr_en    = 1'b1;
            wr_idx   = rest_ff[AW-1:0];
            wr_data  = {1'b1, 1'b0, rest_sz_ff};
            state_in = S_RESP;
         end
         S_FCHK: begin
            if (!ready_ff || p_ff < HDR_X || fo >= ARENA_X) begin
               st_in    = ffha_pkg::ST_BADFREE;
               state_in = S_RESP;
            end else begin
               off_in   = fo;
               rd_en    = 1'b1;
               rd_idx   = fo[AW-1:0];
               state_in = S_FEV;
            end
         end
         S_FEV: begin
            if (!rv || !ra) begin
               st_in    = ffha_pkg::ST_BADFREE;
               state_in = S_RESP;
            end else begin
               wr_en    = 1'b1;
               wr_data  = {1'b1, 1'b0, rd_data[AW-1:0]};
               off_in   = '0;
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            // Coalescing walk from the start of the arena.
            if (off_ff >= ARENA_X) begin
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CEV;
            end
         end
         S_CEV: begin
            if (!rv) begin
               state_in = S_RESP;
            end else if (ra || nx_sum >= ARENA_X) begin
               off_in   = nx_sum;
               state_in = S_CRD;
            end else begin
               cur_sz_in = rd_data[AW-1:0];
               nx_in     = nx_sum;
               rd_en     = 1'b1;
               rd_idx    = nx_sum[AW-1:0];
               state_in  = S_CNX;
            end
         end
         S_CNX: begin
            if (rv && !ra) begin
               // Absorb the free neighbor, then look at this block again.
               wr_en    = 1'b1;
               wr_data  = {1'b1, 1'b0, AW'(XW'(cur_sz_ff) + HDR_X + rs)};
               state_in = S_CKILL;
            end else begin
               off_in   = nx_ff;
               state_in = S_CRD;
            end
         end
         S_CKILL: begin
            wr_en    = 1'b1;
            wr_idx   = nx_ff[AW-1:0];
            state_in = S_CRD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = addr_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      off_ff        <= off_in;
      nx_ff         <= nx_in;
      cur_sz_ff     <= cur_sz_in;
      req_sz_ff     <= req_sz_in;
      p_ff          <= p_in;
      rest_ff       <= rest_in;
      rest_sz_ff    <= rest_sz_in;
      st_ff         <= st_in;
      addr_ff       <= addr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // No request is taken while the header memory is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request ready during clearing pass");

   // A failed or free response never carries an address.
   a_addr_on_ok_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffha_pkg::ST_OK) |-> (rsp_granted_address == 12'd0))
      else $error("address on a failed response");

   // Header memory writes stay inside the arena.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (XW'(wr_idx) < ARENA_X))
      else $error("header write outside the arena");

endmodule

/* src/ffha_hdr_ram.sv */
// Block header memory: one write port and one registered read port.
module ffha_hdr_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 14,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_idx,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_idx,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
